@@ design/vram_rectangle_read_engine_assert.svh @@
// assertion macros for the rectangle read engine
`ifndef VRAM_RECTANGLE_READ_ENGINE_ASSERT_SVH
`define VRAM_RECTANGLE_READ_ENGINE_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, off during reset
`define VRRE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vrre assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define VRRE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vrre assertion failed");
`else
`define VRRE_ASSERT_IMPL(lbl, ante, cons)
`define VRRE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ design/vrre_pkg.sv @@
// shared types and constants of the rectangle read engine
package vrre_pkg;

  // halfwords per video line
  localparam int LINE_HALFWORDS = 1024;

  // request kinds
  localparam logic [1:0] REQ_STORE = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LO,
    ST_HI,
    ST_FIN
  } vrre_state_t;

  // request payload
  typedef struct packed {
    logic [1:0]  req_type;
    logic [18:0] store_address;
    logic [15:0] store_value;
    logic [9:0]  rect_x;
    logic [8:0]  rect_y;
    logic [10:0] rect_width;
    logic [9:0]  rect_height;
  } vrre_req_t;

  // result payload
  typedef struct packed {
    logic [31:0] read_data;
    logic        transfer_done;
    logic        ready_for_vram;
  } vrre_rsp_t;

endpackage

@@ design/vrre_stream_if.sv @@
// valid/ready stream interface carrying one payload type
interface vrre_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ design/vram_rectangle_read_engine.sv @@
// top level of the rectangle read engine
//
// Video memory of VRAM_LINES lines of 1024 16-bit pixels, with a read-back
// engine that walks a rectangle and returns it as 32-bit words, low half
// first. After reset the pixel memory is cleared one halfword per cycle, and no
// request is taken until that pass ends. Store and start requests are answered
// in the cycle after they are taken. A read request that fetches data occupies
// the engine through the accept cycle in ST_IDLE, then two halfword accesses on
// the single memory port in ST_LO and ST_HI, then ST_FIN for the registered read
// data of the second access; other reads answer in the next cycle. Each step of
// the walk goes through one shared pointer adder with modulo wrap, which also
// wraps the store and start addresses.
`include "vram_rectangle_read_engine_assert.svh"
module vram_rectangle_read_engine #(
  parameter int VRAM_LINES = 512
) (
  input  logic         clk,
  input  logic         rst_n,
  vrre_stream_if.sink   in_req,
  vrre_stream_if.source out_rsp
);
  import vrre_pkg::*;

  localparam int MEM_WORDS = VRAM_LINES * LINE_HALFWORDS;
  localparam int AW        = $clog2(MEM_WORDS);
  localparam int EW        = AW + 2;
  localparam logic [EW-1:0] MEM_EXT = EW'(MEM_WORDS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_WORDS - 1);

  vrre_state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [10:0]   left_r, left_nxt;
  logic [9:0]    lines_r, lines_nxt;
  logic [10:0]   width_r, width_nxt;
  logic [EW-1:0] skip_r, skip_nxt;
  logic [31:0]   last_word_r, last_word_nxt;
  logic [15:0]   lo_r, lo_nxt;
  logic          active_r, active_nxt;
  logic          out_valid_r, out_valid_nxt;
  vrre_rsp_t     out_data_r, out_data_nxt;

  vrre_req_t     req;
  logic          in_ready;
  logic          in_fire;

  // shared pointer unit
  logic [18:0]   addr_src;
  logic [EW-1:0] base_ext;
  logic [EW-1:0] delta_ext;
  logic [EW-1:0] sum;
  logic [EW-1:0] wrapped;
  logic [AW-1:0] wrap_addr;
  logic          row_end;
  logic [10:0]   adv_left;
  logic [9:0]    adv_lines;

  // memory port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [15:0]   ram_wdata;
  logic [15:0]   ram_rdata;
  logic [31:0]   word;

  assign req      = in_req.payload;
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_rsp.ready);
  assign in_fire  = in_req.valid && in_ready;

  assign in_req.ready    = in_ready;
  assign out_rsp.valid   = out_valid_r;
  assign out_rsp.payload = out_data_r;

  // pointer unit: base plus delta, wrapped into the memory size
  assign addr_src  = (req.req_type == REQ_STORE) ? req.store_address
                                                 : {req.rect_y, req.rect_x};
  assign row_end   = (left_r == 11'd1);
  assign base_ext  = (state_r == ST_IDLE) ? EW'(addr_src) : EW'(ptr_r);
  assign delta_ext = (state_r == ST_IDLE) ? '0 : (row_end ? skip_r : EW'(1));
  assign sum       = base_ext + delta_ext;

  always_comb begin
    if (sum[EW-1]) begin
      wrapped = sum + MEM_EXT;
    end else if (sum >= MEM_EXT) begin
      wrapped = sum - MEM_EXT;
    end else begin
      wrapped = sum;
    end
  end

  assign wrap_addr = wrapped[AW-1:0];
  assign adv_left  = row_end ? width_r : left_r - 11'd1;
  assign adv_lines = row_end ? lines_r - 10'd1 : lines_r;
  assign word      = {ram_rdata, lo_r};

  // pixel memory
  vrre_ram #(
    .WIDTH (16),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      ptr_r       <= '0;
      left_r      <= '0;
      lines_r     <= '0;
      width_r     <= '0;
      last_word_r <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      ptr_r       <= ptr_nxt;
      left_r      <= left_nxt;
      lines_r     <= lines_nxt;
      width_r     <= width_nxt;
      last_word_r <= last_word_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    skip_r     <= skip_nxt;
    lo_r       <= lo_nxt;
    out_data_r <= out_data_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    ptr_nxt       = ptr_r;
    left_nxt      = left_r;
    lines_nxt     = lines_r;
    width_nxt     = width_r;
    skip_nxt      = skip_r;
    last_word_nxt = last_word_r;
    lo_nxt        = lo_r;
    active_nxt    = active_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_addr      = ptr_r;
    ram_wdata     = req.store_value;

    case (state_r)
      ST_CLEAR: begin
        // zero the memory after reset
        ram_we      = 1'b1;
        ram_addr    = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{read_data: last_word_r, transfer_done: 1'b0,
                            ready_for_vram: active_r};
          case (req.req_type)
            REQ_STORE: begin
              ram_we   = 1'b1;
              ram_addr = wrap_addr;
            end
            REQ_START: begin
              ptr_nxt    = wrap_addr;
              width_nxt  = req.rect_width;
              left_nxt   = req.rect_width;
              lines_nxt  = req.rect_height;
              skip_nxt   = EW'(LINE_HALFWORDS + 1) - EW'(req.rect_width);
              active_nxt = 1'b1;
              out_data_nxt.ready_for_vram = 1'b1;
            end
            REQ_READ: begin
              if (active_r) begin
                if (lines_r != '0 && left_r != '0) begin
                  // result comes at the end of the walk
                  out_valid_nxt = 1'b0;
                  state_nxt     = ST_LO;
                end else begin
                  // empty rectangle ends at once
                  active_nxt = 1'b0;
                  left_nxt   = '0;
                  lines_nxt  = '0;
                  width_nxt  = '0;
                  out_data_nxt.transfer_done  = 1'b1;
                  out_data_nxt.ready_for_vram = 1'b0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LO: begin
        // fetch low half, step the pointer
        ptr_nxt   = wrap_addr;
        left_nxt  = adv_left;
        lines_nxt = adv_lines;
        state_nxt = ST_HI;
      end
      ST_HI: begin
        // fetch high half, step again unless the rectangle ran out
        lo_nxt = ram_rdata;
        if (lines_r != '0) begin
          ptr_nxt   = wrap_addr;
          left_nxt  = adv_left;
          lines_nxt = adv_lines;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // pack the word and close the transfer on the last row
        last_word_nxt = word;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{read_data: word, transfer_done: 1'b0,
                          ready_for_vram: 1'b1};
        if (lines_r == '0) begin
          active_nxt = 1'b0;
          left_nxt   = '0;
          width_nxt  = '0;
          out_data_nxt.transfer_done  = 1'b1;
          out_data_nxt.ready_for_vram = 1'b0;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // checks
  `VRRE_ASSERT_IMPL(a_clear_blocks_requests, state_r == ST_CLEAR, !in_ready)
  `VRRE_ASSERT_NEXT(a_lo_then_hi, state_r == ST_LO, state_r == ST_HI)
  `VRRE_ASSERT_IMPL(a_no_result_mid_walk, state_r == ST_LO || state_r == ST_HI, !out_valid_r)
  `VRRE_ASSERT_IMPL(a_idle_counts_zero, !active_r, lines_r == '0 && left_r == '0)
  `VRRE_ASSERT_IMPL(a_ptr_in_range, state_r != ST_CLEAR, ptr_r <= LAST_ADDR)

endmodule

@@ design/vrre_ram.sv @@
// generic single-port ram with registered read
module vrre_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end
endmodule
